// ===== rtl/rnqt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rnqt_pkg
// Shared types and constants for the redundant node quorum tracker.
// ----------------------------------------------------------------------------
package rnqt_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 5;
    localparam int EV_W   = 2;
    localparam int CNT_W  = 6;
    localparam int RED_W  = 4;
    localparam int TICK_W = 16;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    localparam logic [CNT_W-1:0]  TOTAL_NODES_RST = 6'd3;
    localparam logic [RED_W-1:0]  REDUNDANCY_RST  = 4'd1;
    localparam logic [TICK_W-1:0] GRACE_TICKS_RST = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_MEMBER_UP   = 2'd0,
        CMD_MEMBER_DOWN = 2'd1,
        CMD_PARENT_UP   = 2'd2,
        CMD_TICK        = 2'd3
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_UP       = 2'd0,
        EV_DOWN     = 2'd1,
        EV_MODIFIED = 2'd2,
        EV_NONE     = 2'd3
    } event_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_TOTAL_NODES = 2'd0,
        REG_REDUNDANCY  = 2'd1,
        REG_GRACE_TICKS = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

endpackage
`default_nettype wire

// ===== rtl/redundant_node_quorum_tracker_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// redundant_node_quorum_tracker_top
// Member report and up masks with counts, block-up flag and grace timer.
//
// Usage:
//   Request channel (req_valid/req_ready) carries command and node_index:
//   member up, member down, parent up or timer tick. Result channel
//   (res_valid/res_ready) carries group_event, group_is_up and members_up.
//   Member events and timer expiry give at most one result; parent up and
//   plain ticks give none.
//   A request lands in the request register, is resolved by single-pass
//   logic that updates the masks, counts, flag and timer once any held result
//   is taken, and its result is held in the result register. One request per
//   cycle is sustained while the result side takes one per cycle; res_ready
//   reaches req_ready combinationally.
//   When the receiver stalls, the held result blocks the next resolve and the
//   request register fills, then req_ready drops.
//   Reset clears the masks, counts, flag, timer and both channel valid bits,
//   and loads total_nodes 3, redundancy 1, grace_ticks 10. Write registers
//   through cfg_we/cfg_index/cfg_data only while the block is idle.
// ----------------------------------------------------------------------------
module redundant_node_quorum_tracker_top #(
    parameter int MAX_NODES = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [rnqt_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [rnqt_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic [rnqt_pkg::CMD_W-1:0]  command,
    input  wire logic [rnqt_pkg::IDX_W-1:0]  node_index,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic [rnqt_pkg::EV_W-1:0]        group_event,
    output logic                             group_is_up,
    output logic [rnqt_pkg::CNT_W-1:0]       members_up
);

    localparam int CNT_W = rnqt_pkg::CNT_W;
    localparam logic [CNT_W-1:0] MAX_NODES_C = CNT_W'(MAX_NODES);

    logic [CNT_W-1:0]            total_nodes_reg;
    logic [rnqt_pkg::RED_W-1:0]  redundancy_reg;
    logic [rnqt_pkg::TICK_W-1:0] grace_ticks_reg;

    logic                        req_valid_reg;
    rnqt_pkg::cmd_t              cmd_reg;
    logic [rnqt_pkg::IDX_W-1:0]  idx_reg;

    logic [MAX_NODES-1:0]        reported_reg, reported_next;
    logic [MAX_NODES-1:0]        up_mask_reg, up_mask_next;
    logic [CNT_W-1:0]            reported_cnt_reg, reported_cnt_next;
    logic [CNT_W-1:0]            up_cnt_reg, up_cnt_next;
    logic                        up_flag_reg, up_flag_next;
    logic                        timer_run_reg, timer_run_next;
    logic [rnqt_pkg::TICK_W-1:0] timer_rem_reg, timer_rem_next;

    logic                        res_valid_reg;
    rnqt_pkg::event_t            res_event_reg;
    logic                        res_up_reg;
    logic [CNT_W-1:0]            res_cnt_reg;

    logic                        proc_fire;
    logic                        emit;
    rnqt_pkg::event_t            ev;
    rnqt_pkg::event_t            old_ev;
    logic [CNT_W-1:0]            nodes;
    logic [MAX_NODES-1:0]        sel;
    logic [MAX_NODES-1:0]        fill;
    logic                        idx_ok;
    logic                        was_reported;
    logic                        was_up;

    function automatic rnqt_pkg::event_t derive(
        input logic [CNT_W-1:0]           n,
        input logic [rnqt_pkg::RED_W-1:0] red,
        input logic [CNT_W-1:0]           upc,
        input logic [CNT_W-1:0]           rep,
        input logic                       run
    );
        logic signed [CNT_W+1:0] frag;
        logic signed [CNT_W+1:0] up_s;
        logic signed [CNT_W+1:0] rep_s;
        logic signed [CNT_W+1:0] red_s;
        logic signed [CNT_W+1:0] n_s;
        rnqt_pkg::event_t        r;
        n_s   = $signed({2'b00, n});
        up_s  = $signed({2'b00, upc});
        rep_s = $signed({2'b00, rep});
        red_s = $signed({{(CNT_W+2-rnqt_pkg::RED_W){1'b0}}, red});
        frag  = n_s - red_s;
        if (up_s >= frag)
        begin
            r = (run && (rep_s < n_s)) ? rnqt_pkg::EV_NONE : rnqt_pkg::EV_UP;
        end
        else if ((rep_s - up_s) > red_s)
        begin
            r = rnqt_pkg::EV_DOWN;
        end
        else
        begin
            r = rnqt_pkg::EV_NONE;
        end
        return r;
    endfunction

    assign proc_fire = req_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !req_valid_reg || proc_fire;

    assign nodes = (total_nodes_reg > MAX_NODES_C) ? MAX_NODES_C : total_nodes_reg;
    assign idx_ok = {1'b0, idx_reg} < nodes;

    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            sel[i]  = ({1'b0, idx_reg} == CNT_W'(i));
            fill[i] = (CNT_W'(i) < nodes);
        end
    end

    assign was_reported = |(reported_reg & sel);
    assign was_up       = |(up_mask_reg & sel);

    always_comb
    begin
        reported_next     = reported_reg;
        up_mask_next      = up_mask_reg;
        reported_cnt_next = reported_cnt_reg;
        up_cnt_next       = up_cnt_reg;
        up_flag_next      = up_flag_reg;
        timer_run_next    = timer_run_reg;
        timer_rem_next    = timer_rem_reg;
        ev                = rnqt_pkg::EV_NONE;
        old_ev            = rnqt_pkg::EV_NONE;
        case (cmd_reg)
            rnqt_pkg::CMD_MEMBER_UP, rnqt_pkg::CMD_MEMBER_DOWN:
            begin
                if (idx_ok)
                begin
                    old_ev = derive(nodes, redundancy_reg, up_cnt_reg, reported_cnt_reg,
                                    timer_run_reg);
                    reported_next = reported_reg | sel;
                    if (!was_reported)
                    begin
                        reported_cnt_next = reported_cnt_reg + CNT_W'(1);
                    end
                    if (cmd_reg == rnqt_pkg::CMD_MEMBER_UP)
                    begin
                        up_mask_next = up_mask_reg | sel;
                        if (!was_up)
                        begin
                            up_cnt_next = up_cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        up_mask_next = up_mask_reg & ~sel;
                        if (was_up)
                        begin
                            up_cnt_next = up_cnt_reg - CNT_W'(1);
                        end
                    end
                    ev = derive(nodes, redundancy_reg, up_cnt_next, reported_cnt_next,
                                timer_run_reg);
                    if ((ev == rnqt_pkg::EV_UP) && !up_flag_reg)
                    begin
                        timer_run_next = 1'b0;
                        timer_rem_next = '0;
                        up_flag_next   = 1'b1;
                    end
                    else if ((ev == rnqt_pkg::EV_DOWN) && up_flag_reg)
                    begin
                        timer_run_next = 1'b0;
                        timer_rem_next = '0;
                        up_flag_next   = 1'b0;
                    end
                    if ((ev == old_ev) && (ev != rnqt_pkg::EV_NONE))
                    begin
                        ev = rnqt_pkg::EV_MODIFIED;
                    end
                end
            end
            rnqt_pkg::CMD_PARENT_UP:
            begin
                timer_run_next = 1'b1;
                timer_rem_next = grace_ticks_reg;
            end
            rnqt_pkg::CMD_TICK:
            begin
                if (timer_run_reg)
                begin
                    if (timer_rem_reg > rnqt_pkg::TICK_W'(1))
                    begin
                        timer_rem_next = timer_rem_reg - rnqt_pkg::TICK_W'(1);
                    end
                    else
                    begin
                        timer_rem_next = '0;
                        timer_run_next = 1'b0;
                        ev = derive(nodes, redundancy_reg, up_cnt_reg, reported_cnt_reg, 1'b0);
                        if (ev == rnqt_pkg::EV_NONE)
                        begin
                            ev                = rnqt_pkg::EV_DOWN;
                            reported_next     = fill;
                            reported_cnt_next = nodes;
                        end
                        else if (ev == rnqt_pkg::EV_UP)
                        begin
                            up_flag_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                ev = rnqt_pkg::EV_NONE;
            end
        endcase
    end

    assign emit = (ev != rnqt_pkg::EV_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_nodes_reg <= rnqt_pkg::TOTAL_NODES_RST;
            redundancy_reg  <= rnqt_pkg::REDUNDANCY_RST;
            grace_ticks_reg <= rnqt_pkg::GRACE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (rnqt_pkg::reg_idx_t'(cfg_index))
                rnqt_pkg::REG_TOTAL_NODES: total_nodes_reg <= cfg_data[CNT_W-1:0];
                rnqt_pkg::REG_REDUNDANCY:  redundancy_reg  <= cfg_data[rnqt_pkg::RED_W-1:0];
                rnqt_pkg::REG_GRACE_TICKS: grace_ticks_reg <= cfg_data;
                default:                   grace_ticks_reg <= grace_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            reported_reg     <= '0;
            up_mask_reg      <= '0;
            reported_cnt_reg <= '0;
            up_cnt_reg       <= '0;
            up_flag_reg      <= 1'b0;
            timer_run_reg    <= 1'b0;
            timer_rem_reg    <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (proc_fire)
            begin
                reported_reg     <= reported_next;
                up_mask_reg      <= up_mask_next;
                reported_cnt_reg <= reported_cnt_next;
                up_cnt_reg       <= up_cnt_next;
                up_flag_reg      <= up_flag_next;
                timer_run_reg    <= timer_run_next;
                timer_rem_reg    <= timer_rem_next;
                res_valid_reg    <= emit;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload with its valid
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            cmd_reg <= rnqt_pkg::cmd_t'(command);
            idx_reg <= node_index;
        end
        if (proc_fire && emit)
        begin
            res_event_reg <= ev;
            res_up_reg    <= up_flag_next;
            res_cnt_reg   <= up_cnt_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign group_event = res_event_reg;
    assign group_is_up = res_up_reg;
    assign members_up  = res_cnt_reg;

`ifndef ASSERT_OFF
    a_up_count: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'($countones(up_mask_reg)) == up_cnt_reg)
        else $error("up count out of step with up mask");

    a_rep_count: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'($countones(reported_reg)) == reported_cnt_reg)
        else $error("reported count out of step with reported mask");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> res_valid_reg)
        else $error("held result dropped before acceptance");

    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !timer_run_reg |-> (timer_rem_reg == '0))
        else $error("timer holds ticks while stopped");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> ($stable(res_event_reg) && $stable(res_cnt_reg)))
        else $error("held result overwritten");
`endif

endmodule
`default_nettype wire
